@@ hw/rtl/gurp_pkg.sv @@
`timescale 1ns / 1ps

package gurp_pkg;

   // Chunk store geometry
   localparam int CHUNK_BYTES = 32;
   localparam int CHUNK_AW    = $clog2(CHUNK_BYTES);
   localparam int FILL_W      = $clog2(CHUNK_BYTES + 1);

   // Field widths
   localparam int OP_W    = 2;
   localparam int PIX_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int CFG_W   = 4;
   localparam int CODE_W  = 9;
   localparam int WIN_W   = 16;
   localparam int WCNT_W  = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_PIXEL  = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   // pixel_bits value that selects one-bit mode, and the pixel_bits reset value
   localparam logic [CFG_W-1:0] PIX_BITS_ONE   = 4'd1;
   localparam logic [CFG_W-1:0] PIX_BITS_RESET = 4'd8;

   // Code parameters per mode
   localparam logic [BYTE_W-1:0] MIN_SIZE_1 = 8'd2;
   localparam logic [BYTE_W-1:0] MIN_SIZE_8 = 8'd8;
   localparam logic [CODE_W-1:0] CLEAR_1    = 9'd4;
   localparam logic [CODE_W-1:0] CLEAR_8    = 9'd256;
   localparam logic [CODE_W-1:0] END_1      = 9'd5;
   localparam logic [CODE_W-1:0] END_8      = 9'd257;
   localparam logic [WCNT_W-1:0] LEN_1      = 5'd3;
   localparam logic [WCNT_W-1:0] LEN_8      = 5'd9;

   localparam logic [BYTE_W-1:0] TERMINATOR = 8'd0;

endpackage

@@ hw/rtl/gif_uncompressed_raster_packer.sv @@
`timescale 1ns / 1ps

// GIF image-data stream packer without real compression.
//
// Input channel (req_): one transfer per command. req_tuser carries the
// operation (start, pixel, finish), req_tdata the pixel value. The block is
// ready only while its sequencer is idle; one command is worked at a time.
// Result channel (rsp_): one transfer per stream byte, rsp_tlast marks the
// final byte produced by a command. A registered output stage holds each
// byte; the sequencer stalls while that stage is full and not taken.
// csr_wen/csr_wdata write pixel_bits (1 = one-bit mode, else eight-bit).
//
// One shared pack/shift unit loads each code into a 16-bit bit window, then
// peels one byte per cycle into the 32-entry chunk store until under 8 bits
// are left or the chunk fills. Start sends the minimum code size byte; pixel
// packs the pixel code, then the clear code; finish packs the end code, stores
// any partial byte, then sends the last chunk and the terminator. Each chunk
// goes as its length byte, then its bytes (registered read, then output load).
// Reset: sequencer idle, window and fill cleared, pixel_bits = 8, output
// stage empty. The chunk store needs no clearing: only bytes of the current
// chunk are read back.

module gif_uncompressed_raster_packer (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] pixel_value
   input  logic [1:0] req_tuser,   // [1:0] operation
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_run
   // configuration
   input  logic       csr_wen,
   input  logic [3:0] csr_wdata    // pixel_bits
);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_START    = 4'd1;
   localparam logic [3:0] S_PACK     = 4'd2;
   localparam logic [3:0] S_DRAIN    = 4'd3;
   localparam logic [3:0] S_FLUSH    = 4'd4;
   localparam logic [3:0] S_EMIT_LEN = 4'd5;
   localparam logic [3:0] S_EMIT_RD  = 4'd6;
   localparam logic [3:0] S_EMIT_TX  = 4'd7;
   localparam logic [3:0] S_TERM     = 4'd8;

   logic [3:0]                          state_ff, state_in;
   logic [gurp_pkg::CFG_W-1:0]          pix_bits_ff;
   logic [gurp_pkg::OP_W-1:0]           op_ff, op_in;
   logic [gurp_pkg::PIX_W-1:0]          pix_ff, pix_in;
   logic                                code_sel_ff, code_sel_in;   // 0: pixel, 1: clear
   logic                                flushing_ff, flushing_in;   // emission ends in terminator
   logic [gurp_pkg::WIN_W-1:0]          win_ff, win_in;             // bit window
   logic [gurp_pkg::WCNT_W-1:0]         cnt_ff, cnt_in;             // valid bits in window
   logic [gurp_pkg::FILL_W-1:0]         fill_ff, fill_in;           // bytes in chunk store
   logic [gurp_pkg::CHUNK_AW-1:0]       idx_ff, idx_in;             // readout index

   logic                                rsp_valid_ff;
   logic [gurp_pkg::BYTE_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_load;

   // chunk store
   logic [gurp_pkg::BYTE_W-1:0]         chunk_mem [gurp_pkg::CHUNK_BYTES];
   logic [gurp_pkg::BYTE_W-1:0]         rd_q_ff;
   logic                                store_en;

   logic                                out_free;
   logic                                one_bit;
   logic [gurp_pkg::BYTE_W-1:0]         min_size;
   logic [gurp_pkg::CODE_W-1:0]         clear_code, end_code, code;
   logic [gurp_pkg::WCNT_W-1:0]         code_len;
   logic [gurp_pkg::PIX_W-1:0]          pix_used;
   logic [gurp_pkg::FILL_W-1:0]         fill_inc;
   logic [gurp_pkg::FILL_W-1:0]         idx_inc;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign one_bit    = (pix_bits_ff == gurp_pkg::PIX_BITS_ONE);
   assign min_size   = one_bit ? gurp_pkg::MIN_SIZE_1 : gurp_pkg::MIN_SIZE_8;
   assign clear_code = one_bit ? gurp_pkg::CLEAR_1 : gurp_pkg::CLEAR_8;
   assign end_code   = one_bit ? gurp_pkg::END_1 : gurp_pkg::END_8;
   assign code_len   = one_bit ? gurp_pkg::LEN_1 : gurp_pkg::LEN_8;
   assign pix_used   = one_bit ? {{(gurp_pkg::PIX_W-1){1'b0}}, pix_ff[0]} : pix_ff;

   // code fed to the shared pack unit
   always_comb begin
      if (op_ff == gurp_pkg::OP_FINISH) begin
         code = end_code;
      end else if (code_sel_ff) begin
         code = clear_code;
      end else begin
         code = {{(gurp_pkg::CODE_W-gurp_pkg::PIX_W){1'b0}}, pix_used};
      end
   end

   assign fill_inc = fill_ff + gurp_pkg::FILL_W'(1);
   assign idx_inc  = gurp_pkg::FILL_W'(idx_ff) + gurp_pkg::FILL_W'(1);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pix_in      = pix_ff;
      code_sel_in = code_sel_ff;
      flushing_in = flushing_ff;
      win_in      = win_ff;
      cnt_in      = cnt_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      store_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_tuser;
               pix_in      = req_tdata;
               code_sel_in = 1'b0;
               flushing_in = 1'b0;
               case (req_tuser)
                  gurp_pkg::OP_START:  state_in = S_START;
                  gurp_pkg::OP_PIXEL:  state_in = S_PACK;
                  gurp_pkg::OP_FINISH: state_in = S_PACK;
                  default:             state_in = S_IDLE;   // unused code: no effect
               endcase
            end
         end
         S_START: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = min_size;
               rsp_last_in = 1'b1;
               win_in      = '0;
               cnt_in      = '0;
               fill_in     = '0;
               state_in    = S_IDLE;
            end
         end
         S_PACK: begin
            // window holds fewer than 8 bits here, so the code always fits
            win_in   = win_ff | (gurp_pkg::WIN_W'(code) << cnt_ff[2:0]);
            cnt_in   = cnt_ff + code_len;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (cnt_ff >= gurp_pkg::WCNT_W'(8)) begin
               store_en = 1'b1;
               win_in   = win_ff >> 8;
               cnt_in   = cnt_ff - gurp_pkg::WCNT_W'(8);
               fill_in  = fill_inc;
               if (fill_inc == gurp_pkg::FILL_W'(gurp_pkg::CHUNK_BYTES)) begin
                  state_in = S_EMIT_LEN;
               end
            end else if (op_ff == gurp_pkg::OP_FINISH) begin
               state_in = S_FLUSH;
            end else if (!code_sel_ff) begin
               code_sel_in = 1'b1;
               state_in    = S_PACK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            flushing_in = 1'b1;
            win_in      = '0;
            cnt_in      = '0;
            if (cnt_ff != '0) begin
               store_en = 1'b1;
               fill_in  = fill_inc;
               state_in = S_EMIT_LEN;
            end else if (fill_ff != '0) begin
               state_in = S_EMIT_LEN;
            end else begin
               state_in = S_TERM;
            end
         end
         S_EMIT_LEN: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = gurp_pkg::BYTE_W'(fill_ff);
               rsp_last_in = 1'b0;
               idx_in      = '0;
               state_in    = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_TX;   // store read lands in rd_q_ff
         end
         S_EMIT_TX: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = rd_q_ff;
               rsp_last_in = (idx_inc == fill_ff) && (op_ff == gurp_pkg::OP_PIXEL);
               idx_in      = idx_inc[gurp_pkg::CHUNK_AW-1:0];
               if (idx_inc == fill_ff) begin
                  fill_in  = '0;
                  state_in = flushing_ff ? S_TERM : S_DRAIN;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_TERM: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = gurp_pkg::TERMINATOR;
               rsp_last_in = 1'b1;
               flushing_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_sel_ff  <= 1'b0;
         flushing_ff  <= 1'b0;
         win_ff       <= '0;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         code_sel_ff <= code_sel_in;
         flushing_ff <= flushing_in;
         win_ff      <= win_in;
         cnt_ff      <= cnt_in;
         fill_ff     <= fill_in;
         idx_ff      <= idx_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_bits_ff <= gurp_pkg::PIX_BITS_RESET;
      end else if (csr_wen) begin
         pix_bits_ff <= csr_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pix_ff      <= pix_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // chunk store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_en) begin
         chunk_mem[fill_ff[gurp_pkg::CHUNK_AW-1:0]] <= win_ff[7:0];
      end
      rd_q_ff <= chunk_mem[idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // chunk store never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= gurp_pkg::FILL_W'(gurp_pkg::CHUNK_BYTES))
      else $error("chunk fill above chunk size");

   // a code is only loaded into a window holding a partial byte
   a_pack_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PACK) |-> (cnt_ff < gurp_pkg::WCNT_W'(8)))
      else $error("bit window overflow on code load");

   // chunk readout only runs over a non-empty chunk
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT_RD) || (state_ff == S_EMIT_TX)) |-> (fill_ff != '0))
      else $error("chunk readout with empty store");

   // after the terminator the packer and store are empty
   a_term_clean: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_TERM) && out_free) |=>
         ((fill_ff == '0) && (cnt_ff == '0) && rsp_tvalid && rsp_tlast))
      else $error("state left over after finish");
`endif

endmodule

@@ test/gif_stream_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port, rebuilds the image-data byte
// stream on its own and compares every result transfer with it.
module gif_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic [1:0] req_tuser,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   input  logic       csr_wen,
   input  logic [3:0] csr_wdata,
   output int         mismatch_count,
   output int         bytes_pending
);

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } stream_byte_type;

   stream_byte_type expected_bytes[$];

   logic [gurp_pkg::CFG_W-1:0] pixel_bits_q;
   logic [7:0]                 acc_q;
   int unsigned                acc_bits;
   logic [7:0]                 chunk_q [gurp_pkg::CHUNK_BYTES];
   int unsigned                chunk_fill;
   int                         errors = 0;

   task automatic queue_byte(input logic [7:0] b);
      stream_byte_type e;
      e.value = b;
      e.last  = 1'b0;
      expected_bytes.push_back(e);
   endtask

   // length byte, then the chunk contents
   task automatic flush_chunk();
      if (chunk_fill != 0) begin
         queue_byte(chunk_fill[7:0]);
         for (int i = 0; i < chunk_fill; i++)
            queue_byte(chunk_q[i]);
         chunk_fill = 0;
      end
   endtask

   task automatic put_byte(input logic [7:0] b);
      chunk_q[chunk_fill] = b;
      chunk_fill++;
      if (chunk_fill >= gurp_pkg::CHUNK_BYTES)
         flush_chunk();
   endtask

   // LSB-first into the partial byte
   task automatic pack_code(input logic [gurp_pkg::CODE_W-1:0] code, input int unsigned len);
      for (int i = 0; i < len; i++) begin
         acc_q[acc_bits] = code[i];
         acc_bits++;
         if (acc_bits == 8) begin
            put_byte(acc_q);
            acc_q    = '0;
            acc_bits = 0;
         end
      end
   endtask

   task automatic predict_stream(input logic [1:0] op, input logic [7:0] pix);
      logic                        one_bit;
      logic [gurp_pkg::CODE_W-1:0] clear_code;
      logic [gurp_pkg::CODE_W-1:0] end_code;
      int unsigned                 code_len;
      int                          first;
      one_bit    = (pixel_bits_q == gurp_pkg::PIX_BITS_ONE);
      clear_code = one_bit ? gurp_pkg::CLEAR_1 : gurp_pkg::CLEAR_8;
      end_code   = one_bit ? gurp_pkg::END_1 : gurp_pkg::END_8;
      code_len   = one_bit ? gurp_pkg::LEN_1 : gurp_pkg::LEN_8;
      first      = expected_bytes.size();
      case (op)
         gurp_pkg::OP_START: begin
            acc_q      = '0;
            acc_bits   = 0;
            chunk_fill = 0;
            queue_byte(one_bit ? gurp_pkg::MIN_SIZE_1 : gurp_pkg::MIN_SIZE_8);
         end
         gurp_pkg::OP_PIXEL: begin
            pack_code(one_bit ? {8'd0, pix[0]} : {1'b0, pix}, code_len);
            pack_code(clear_code, code_len);
         end
         gurp_pkg::OP_FINISH: begin
            pack_code(end_code, code_len);
            if (acc_bits > 0)
               put_byte(acc_q);
            acc_q    = '0;
            acc_bits = 0;
            flush_chunk();
            queue_byte(gurp_pkg::TERMINATOR);
         end
         default: ;
      endcase
      if (expected_bytes.size() > first)
         expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      stream_byte_type want;
      if (reset) begin
         pixel_bits_q = gurp_pkg::PIX_BITS_RESET;
         acc_q        = '0;
         acc_bits     = 0;
         chunk_fill   = 0;
         expected_bytes.delete();
      end else begin
         // results first: a command accepted at this edge cannot have
         // produced a byte at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected byte %02h last %0b, nothing pending",
                           rsp_tdata, rsp_tlast);
            end else begin
               want = expected_bytes.pop_front();
               if (want.value !== rsp_tdata || want.last !== rsp_tlast) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected byte %02h last %0b, got %02h last %0b",
                              want.value, want.last, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (csr_wen)
            pixel_bits_q = csr_wdata;
         if (req_tvalid && req_tready)
            predict_stream(req_tuser, req_tdata);
      end
      mismatch_count <= errors;
      bytes_pending  <= expected_bytes.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Top of the packer test: makes the command stream, paces both sides,
// writes pixel_bits between phases and gives the verdict. All byte checking
// lives in gif_stream_checker.
module testbench;

   // op code the block must ignore
   localparam logic [gurp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   // cycles without any transfer before the run is declared hung; the
   // longest legal quiet stretch is the forced receiver hold below
   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AT_BYTE  = 150;
   // settle time after the last byte, covers a pixel that stores no byte
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_ITEMS   = 26;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;   // [7:0] pixel_value
   logic [1:0] req_tuser  = '0;   // [1:0] operation
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] out_byte
   logic       rsp_tlast;         // last_of_run
   logic       csr_wen    = 1'b0;
   logic [3:0] csr_wdata  = '0;   // pixel_bits

   int mismatch_count;
   int bytes_pending;

   // pacing knobs, 0 turns idling off for a side
   int unsigned req_gap_max = 16;
   int unsigned rsp_gap_max = 16;

   int commands_sent  = 0;
   int bytes_received = 0;
   int settings_used  = 1;
   int quiet_cycles   = 0;
   bit hold_done      = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   gif_uncompressed_raster_packer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   gif_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   // Watchdog: any transfer on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d bytes pending",
                     quiet_cycles, bytes_pending);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Result side: random stall per byte, plus one long hold so the output
   // stage fills and the block backs up into req_tready.
   initial begin
      int unsigned stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (bytes_received >= HOLD_AT_BYTE && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         bytes_received++;
      end
   end

   // One command transfer. tvalid stays high into the next call when that
   // call draws no gap.
   task automatic send_cmd(input logic [1:0] op, input logic [7:0] pix);
      int unsigned gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      if (op != OP_UNUSED)
         commands_sent++;
   endtask

   // Sender pause until every predicted byte is back, then let a trailing
   // pixel (which may store no byte) finish inside the block.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pixel_bits(input logic [3:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      settings_used++;
   endtask

   // Mostly whole streams with random pixels; some are long enough to fill
   // one or more chunks. The rest are stray commands and streams cut short.
   task automatic random_streams(input int count);
      int sent_here;
      int unsigned kind;
      int unsigned npix;
      logic [1:0] op;
      sent_here = 0;
      while (sent_here < count) begin
         kind = $urandom_range(0, 9);
         npix = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         if (kind == 0) begin
            op = 2'($urandom_range(0, 3));
            send_cmd(op, 8'($urandom_range(0, 255)));
            if (op != OP_UNUSED)
               sent_here++;
         end else begin
            send_cmd(gurp_pkg::OP_START, 8'($urandom_range(0, 255)));
            sent_here++;
            for (int i = 0; i < npix; i++) begin
               send_cmd(gurp_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
               sent_here++;
            end
            // kind 1 leaves the stream open for whatever follows
            if (kind != 1) begin
               send_cmd(gurp_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
               sent_here++;
            end
         end
      end
   endtask

   initial begin
      logic [3:0] settings [7];
      settings = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd1, 4'd2, 4'd0};
      settings[6] = 4'($urandom_range(0, 15));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, eight-bit mode out of reset
      send_cmd(gurp_pkg::OP_PIXEL, 8'hFF);     // pixel before any start
      send_cmd(OP_UNUSED, 8'h5A);              // ignored op
      send_cmd(gurp_pkg::OP_START, 8'h00);
      send_cmd(gurp_pkg::OP_PIXEL, 8'h00);
      send_cmd(gurp_pkg::OP_PIXEL, 8'hFF);
      send_cmd(gurp_pkg::OP_PIXEL, 8'hAA);
      send_cmd(gurp_pkg::OP_START, 8'h00);     // restart drops the partial byte and the unsent chunk
      send_cmd(gurp_pkg::OP_PIXEL, 8'h55);
      send_cmd(gurp_pkg::OP_FINISH, 8'h00);
      send_cmd(gurp_pkg::OP_FINISH, 8'hFF);    // finish on an empty packer
      send_cmd(gurp_pkg::OP_START, 8'h00);
      send_cmd(gurp_pkg::OP_FINISH, 8'h00);
      drain();

      // directed, one-bit mode
      write_pixel_bits(gurp_pkg::PIX_BITS_ONE);
      send_cmd(gurp_pkg::OP_START, 8'h00);
      send_cmd(gurp_pkg::OP_PIXEL, 8'h00);
      send_cmd(gurp_pkg::OP_PIXEL, 8'h01);
      send_cmd(gurp_pkg::OP_PIXEL, 8'hFE);     // only bit 0 counts
      send_cmd(gurp_pkg::OP_PIXEL, 8'hFF);
      send_cmd(OP_UNUSED, 8'hA5);
      send_cmd(gurp_pkg::OP_FINISH, 8'h00);
      send_cmd(gurp_pkg::OP_PIXEL, 8'h01);     // left open across the next write
      drain();

      // random phases, each under its own pixel_bits; phase 3 runs flat out
      foreach (settings[p]) begin
         write_pixel_bits(settings[p]);
         req_gap_max = (p == 3) ? 0 : 16;
         rsp_gap_max = (p == 3) ? 0 : 16;
         random_streams(PHASE_ITEMS);
         drain();
      end

      $display("ran %0d commands under %0d pixel_bits settings, %0d stream bytes",
               commands_sent, settings_used, bytes_received);
      $display("forced receiver hold %0s", hold_done ? "reached" : "not reached");
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ gif_uncompressed_raster_packer.f @@
hw/rtl/gurp_pkg.sv
hw/rtl/gif_uncompressed_raster_packer.sv
test/gif_stream_checker.sv
test/testbench.sv
